/* hw/rtl/at_rx_pkg.sv */
// ----------------------------------------------------------------------------
// at_rx_pkg
// Shared types, codes and reset values for the command reply receiver.
// ----------------------------------------------------------------------------
package at_rx_pkg;

    // default sizes
    localparam int BUF_DEPTH_DEF   = 128;
    localparam int PATTERN_MAX_DEF = 8;

    // widths fixed by the register map and the item fields
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int TIMEOUT_W   = 16;
    localparam int ATTEMPT_W   = 8;
    localparam int PAT_LEN_W   = 4;
    localparam int COUNT_W     = 8;
    localparam int PAT_BYTES   = CFG_DATA_W / 8;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_TO = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_TO  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ATTEMPTS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAT_LEN  = 3'd4;

    // register reset values
    localparam logic [TIMEOUT_W-1:0]  RST_FIRST_TO = 16'd1000;
    localparam logic [TIMEOUT_W-1:0]  RST_IDLE_TO  = 16'd50;
    localparam logic [ATTEMPT_W-1:0]  RST_ATTEMPTS = 8'd1;
    localparam logic [CFG_DATA_W-1:0] RST_PATTERN  = 64'd0;
    localparam logic [PAT_LEN_W-1:0]  RST_PAT_LEN  = 4'd0;

    localparam logic [TIMEOUT_W-1:0] TICKS_MAX = {TIMEOUT_W{1'b1}};

    typedef enum logic [1:0] {
        FN_TICK  = 2'd0,
        FN_BYTE  = 2'd1,
        FN_START = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_WAIT = 2'd0,
        ST_OK   = 2'd1,
        ST_FAIL = 2'd2,
        ST_IDLE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FIRST = 2'd1,
        PH_RECV  = 2'd2
    } t_phase;

endpackage

/* hw/rtl/at_response_receiver_core.sv */
// ----------------------------------------------------------------------------
// at_response_receiver_core
// Times out and checks the serial reply to a command, with resends.
// ----------------------------------------------------------------------------
// Each input transfer is a 1 ms tick, a received byte or a start request, and
// gives exactly one result transfer (status, send pulse, bytes stored). The
// block takes one transfer per clock while o_in_stall is low: an input
// register feeds one pass of short logic that updates the receiver state
// and loads the result register from that pass. The input register
// keeps taking transfers while a result waits on a stalled output; stall is
// raised only when both registers are full and the output is stalled. A reply
// ends on the first-character timeout, or on idle_timeout ticks of silence
// after a byte; an idle_timeout of zero ends it on the byte itself. Up to
// BUF_DEPTH bytes are counted per attempt. Pattern matching is done as bytes
// arrive over a window of the last PATTERN_MAX bytes, up to the first zero
// byte of the reply, so a pattern written mid-reply only affects later bytes.
// A matched (or, with an empty pattern, any nonempty) reply reports ok; any
// other ending pulses send_command while attempts remain, else reports fail.
// Configuration must only be written while no transfer is in flight.
// ----------------------------------------------------------------------------
module at_response_receiver_core #(
    parameter int BUF_DEPTH   = at_rx_pkg::BUF_DEPTH_DEF,
    parameter int PATTERN_MAX = at_rx_pkg::PATTERN_MAX_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [at_rx_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [at_rx_pkg::CFG_DATA_W-1:0]   i_cfg_data,

    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_func,
    input  logic [7:0]                         i_rx_byte,

    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [1:0]                         o_status,
    output logic                               o_send_command,
    output logic [at_rx_pkg::COUNT_W-1:0]      o_bytes_stored
);
    import at_rx_pkg::*;

    localparam int LEN_W    = $clog2(PATTERN_MAX + 1);
    localparam int RECENT_W = 8 * PATTERN_MAX;

    // configuration registers
    logic [TIMEOUT_W-1:0]  r_cfg_first_to;
    logic [TIMEOUT_W-1:0]  r_cfg_idle_to;
    logic [ATTEMPT_W-1:0]  r_cfg_attempts;
    logic [CFG_DATA_W-1:0] r_cfg_pattern;
    logic [PAT_LEN_W-1:0]  r_cfg_pat_len;

    // input register
    logic       r_in_valid;
    logic [1:0] r_in_func;
    logic [7:0] r_in_byte;

    // receiver state
    t_phase                r_phase,   n_phase;
    logic [TIMEOUT_W-1:0]  r_elapsed, n_elapsed;
    logic [COUNT_W-1:0]    r_count,   n_count;
    logic [ATTEMPT_W-1:0]  r_atts,    n_atts;
    logic [RECENT_W-1:0]   r_recent,  n_recent;
    logic [LEN_W-1:0]      r_fill,    n_fill;
    logic                  r_seen,    n_seen;
    logic                  r_ended,   n_ended;

    // result register
    logic                  r_out_valid;
    t_status               r_status,  n_status;
    logic                  r_send,    n_send;
    logic [COUNT_W-1:0]    r_out_count;

    logic w_in_take;
    logic w_adv;
    logic w_out_take;

    logic [7:0]       w_pat [PAT_BYTES];
    logic [LEN_W-1:0] w_eff_len;

    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_in_take  = i_in_valid && !o_in_stall;
    assign w_out_take = r_out_valid && !i_out_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_first_to <= RST_FIRST_TO;
            r_cfg_idle_to  <= RST_IDLE_TO;
            r_cfg_attempts <= RST_ATTEMPTS;
            r_cfg_pattern  <= RST_PATTERN;
            r_cfg_pat_len  <= RST_PAT_LEN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIRST_TO: r_cfg_first_to <= i_cfg_data[TIMEOUT_W-1:0];
                CFG_IDLE_TO:  r_cfg_idle_to  <= i_cfg_data[TIMEOUT_W-1:0];
                CFG_ATTEMPTS: r_cfg_attempts <= i_cfg_data[ATTEMPT_W-1:0];
                CFG_PATTERN:  r_cfg_pattern  <= i_cfg_data;
                CFG_PAT_LEN:  r_cfg_pat_len  <= i_cfg_data[PAT_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective pattern length: clipped, then cut at the first zero byte
    always_comb begin
        logic [PAT_LEN_W-1:0] clip;
        for (int k = 0; k < PAT_BYTES; k++) begin
            w_pat[k] = r_cfg_pattern[8*k +: 8];
        end
        clip = (r_cfg_pat_len > PAT_LEN_W'(PATTERN_MAX)) ? PAT_LEN_W'(PATTERN_MAX)
                                                         : r_cfg_pat_len;
        w_eff_len = LEN_W'(clip);
        for (int k = PATTERN_MAX - 1; k >= 0; k--) begin
            if (PAT_LEN_W'(k) < clip && w_pat[k] == 8'd0) begin
                w_eff_len = LEN_W'(k);
            end
        end
    end

    // one pass of the receiver for the item in the input register
    always_comb begin
        logic       do_attempt;
        logic       do_finish;
        logic       hit;
        logic [2:0] pidx;

        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_count   = r_count;
        n_atts    = r_atts;
        n_recent  = r_recent;
        n_fill    = r_fill;
        n_seen    = r_seen;
        n_ended   = r_ended;
        n_status  = (r_phase == PH_IDLE) ? ST_IDLE : ST_WAIT;
        n_send    = 1'b0;
        do_attempt = 1'b0;
        do_finish  = 1'b0;
        hit        = 1'b1;
        pidx       = 3'd0;

        case (r_in_func)
            FN_START: begin
                n_atts     = r_cfg_attempts;
                do_attempt = 1'b1;
            end
            FN_TICK: begin
                if (r_phase != PH_IDLE) begin
                    if (r_elapsed != TICKS_MAX) begin
                        n_elapsed = r_elapsed + 1'b1;
                    end
                    if (r_phase == PH_FIRST) begin
                        do_attempt = (n_elapsed >= r_cfg_first_to);
                    end else begin
                        do_finish = (n_elapsed >= r_cfg_idle_to);
                    end
                end
            end
            FN_BYTE: begin
                if (r_phase != PH_IDLE) begin
                    n_phase   = PH_RECV;
                    n_elapsed = '0;
                    if (r_count < COUNT_W'(BUF_DEPTH)) begin
                        n_count = r_count + 1'b1;
                        if (!r_ended) begin
                            if (r_in_byte == 8'd0) begin
                                n_ended = 1'b1;
                            end else begin
                                n_recent = RECENT_W'({r_recent, r_in_byte});
                                if (r_fill != LEN_W'(PATTERN_MAX)) begin
                                    n_fill = r_fill + 1'b1;
                                end
                                // newest byte lines up with the last pattern byte
                                for (int i = 0; i < PATTERN_MAX; i++) begin
                                    if (LEN_W'(i) < w_eff_len) begin
                                        pidx = 3'(w_eff_len - LEN_W'(i) - LEN_W'(1));
                                        if (n_recent[8*i +: 8] != w_pat[pidx]) begin
                                            hit = 1'b0;
                                        end
                                    end
                                end
                                if (w_eff_len != '0 && n_fill >= w_eff_len && hit) begin
                                    n_seen = 1'b1;
                                end
                            end
                        end
                    end
                    do_finish = (r_cfg_idle_to == '0);
                end
            end
            default: ;
        endcase

        if (do_finish) begin
            if (n_count != '0 && (w_eff_len == '0 || n_seen)) begin
                n_phase  = PH_IDLE;
                n_status = ST_OK;
            end else begin
                do_attempt = 1'b1;
            end
        end

        if (do_attempt) begin
            if (n_atts != '0) begin
                n_atts    = n_atts - 1'b1;
                n_send    = 1'b1;
                n_status  = ST_WAIT;
                n_phase   = PH_FIRST;
                n_elapsed = '0;
                n_count   = '0;
                n_recent  = '0;
                n_fill    = '0;
                n_seen    = 1'b0;
                n_ended   = 1'b0;
            end else begin
                n_phase  = PH_IDLE;
                n_status = ST_FAIL;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_func <= i_func;
            r_in_byte <= i_rx_byte;
        end
    end

    // receiver state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_elapsed   <= '0;
            r_count     <= '0;
            r_atts      <= '0;
            r_recent    <= '0;
            r_fill      <= '0;
            r_seen      <= 1'b0;
            r_ended     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_phase     <= n_phase;
                r_elapsed   <= n_elapsed;
                r_count     <= n_count;
                r_atts      <= n_atts;
                r_recent    <= n_recent;
                r_fill      <= n_fill;
                r_seen      <= n_seen;
                r_ended     <= n_ended;
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_status    <= n_status;
            r_send      <= n_send;
            r_out_count <= n_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_send_command = r_send;
    assign o_bytes_stored = r_out_count;

    // a send pulse always opens a fresh attempt
    a_send_opens_attempt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_send_command |-> o_status == ST_WAIT && r_phase == PH_FIRST)
        else $error("send pulse without a fresh attempt");

    // a final verdict leaves the receiver idle
    a_verdict_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_OK || o_status == ST_FAIL) |-> r_phase == PH_IDLE)
        else $error("verdict given while still receiving");

    // stored byte count stays within the store
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(BUF_DEPTH) && r_fill <= LEN_W'(PATTERN_MAX))
        else $error("byte count or window fill out of range");

    // an item held in the input register is never dropped
    a_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid)
        else $error("held input item lost");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for at_response_receiver_core. Ticks, reply bytes and
// start requests go in through a valid/stall channel with random gaps. A
// tracker class mirrors the receiver state, works out the status, send pulse
// and byte count for each input transfer, and checks them in order against
// the result channel, which is stalled at random.
// ----------------------------------------------------------------------------
module tb_top;

    import at_rx_pkg::*;

    localparam int ITEM_GOAL   = 850;   // input transfers that reach the receiver
    localparam int PHASE_ITEMS = 110;   // transfers between register settings
    localparam int IDLE_LIMIT  = 2000;  // cycles with no transfer before giving up

    // one result transfer as the bench expects it
    typedef struct {
        t_status            status;
        logic               send;
        logic [COUNT_W-1:0] count;
    } t_reply;

    // ------------------------------------------------------------------------
    // mirror of the receiver: registers, reply state and the results owed
    // ------------------------------------------------------------------------
    class t_reply_tracker;
        logic [TIMEOUT_W-1:0]  first_to;
        logic [TIMEOUT_W-1:0]  idle_to;
        logic [ATTEMPT_W-1:0]  att_limit;
        logic [CFG_DATA_W-1:0] pattern;
        logic [PAT_LEN_W-1:0]  pat_len;

        t_phase                phase;
        logic [TIMEOUT_W-1:0]  elapsed;
        int unsigned           stored;
        logic [ATTEMPT_W-1:0]  tries_left;
        logic [CFG_DATA_W-1:0] recent;
        int unsigned           fill;
        bit                    seen;
        bit                    ended;

        t_reply                due_replies[$];
        int                    errors;

        function new();
            first_to   = RST_FIRST_TO;
            idle_to    = RST_IDLE_TO;
            att_limit  = RST_ATTEMPTS;
            pattern    = RST_PATTERN;
            pat_len    = RST_PAT_LEN;
            phase      = PH_IDLE;
            elapsed    = '0;
            stored     = 0;
            tries_left = '0;
            recent     = '0;
            fill       = 0;
            seen       = 1'b0;
            ended      = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FIRST_TO: first_to  = data[TIMEOUT_W-1:0];
                CFG_IDLE_TO:  idle_to   = data[TIMEOUT_W-1:0];
                CFG_ATTEMPTS: att_limit = data[ATTEMPT_W-1:0];
                CFG_PATTERN:  pattern   = data;
                CFG_PAT_LEN:  pat_len   = data[PAT_LEN_W-1:0];
                default: ;
            endcase
        endfunction

        // pattern length in use: clipped to the window, cut at a zero byte
        function int unsigned pattern_len();
            int unsigned n;
            int unsigned i;
            n = (pat_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : pat_len;
            for (i = 0; i < n; i++) begin
                if (pattern[8*i +: 8] == 8'h00) return i;
            end
            return n;
        endfunction

        function void take_byte(logic [7:0] b);
            int unsigned len;
            int unsigned i;
            bit          hit;
            if (stored >= BUF_DEPTH_DEF) return;
            stored++;
            if (ended) return;
            if (b == 8'h00) begin
                ended = 1'b1;
                return;
            end
            recent = {recent[CFG_DATA_W-9:0], b};
            if (fill < PATTERN_MAX_DEF) fill++;
            len = pattern_len();
            if (len == 0 || fill < len) return;
            hit = 1'b1;
            for (i = 0; i < len; i++) begin
                if (recent[8*i +: 8] != pattern[8*(len-1-i) +: 8]) hit = 1'b0;
            end
            if (hit) seen = 1'b1;
        endfunction

        // resend while attempts remain, otherwise give up
        function t_status retry(inout logic send);
            if (tries_left > 0) begin
                tries_left--;
                send    = 1'b1;
                phase   = PH_FIRST;
                elapsed = '0;
                stored  = 0;
                recent  = '0;
                fill    = 0;
                seen    = 1'b0;
                ended   = 1'b0;
                return ST_WAIT;
            end
            phase = PH_IDLE;
            return ST_FAIL;
        endfunction

        function t_status close_reply(inout logic send);
            if (stored > 0 && (pattern_len() == 0 || seen)) begin
                phase = PH_IDLE;
                return ST_OK;
            end
            return retry(send);
        endfunction

        // returns 1 when the transfer was not simply ignored by an idle receiver
        function bit note_input(logic [1:0] func, logic [7:0] b);
            t_reply  r;
            logic    send;
            t_status st;
            bit      active;
            active = (phase != PH_IDLE) || (func == FN_START);
            send   = 1'b0;
            st     = (phase == PH_IDLE) ? ST_IDLE : ST_WAIT;
            case (func)
                FN_START: begin
                    tries_left = att_limit;
                    st = retry(send);
                end
                FN_TICK: begin
                    if (phase != PH_IDLE) begin
                        if (elapsed != TICKS_MAX) elapsed++;
                        if (phase == PH_FIRST) begin
                            if (elapsed >= first_to) st = retry(send);
                        end else if (elapsed >= idle_to) begin
                            st = close_reply(send);
                        end
                    end
                end
                FN_BYTE: begin
                    if (phase != PH_IDLE) begin
                        phase   = PH_RECV;
                        elapsed = '0;
                        take_byte(b);
                        if (elapsed >= idle_to) st = close_reply(send);
                    end
                end
                default: ;
            endcase
            r.status = st;
            r.send   = send;
            r.count  = stored[COUNT_W-1:0];
            due_replies.push_back(r);
            return active;
        endfunction

        function void check_result(logic [1:0] st, logic snd, logic [COUNT_W-1:0] cnt);
            t_reply e;
            if (due_replies.size() == 0) begin
                $display("%0t: result with none expected: status %0d send %0d count %0d",
                         $time, st, snd, cnt);
                errors++;
                return;
            end
            e = due_replies.pop_front();
            if (st !== e.status) begin
                $display("%0t: status expected %0d got %0d", $time, e.status, st);
                errors++;
            end
            if (snd !== e.send) begin
                $display("%0t: send_command expected %0d got %0d", $time, e.send, snd);
                errors++;
            end
            if (cnt !== e.count) begin
                $display("%0t: bytes_stored expected %0d got %0d", $time, e.count, cnt);
                errors++;
            end
        endfunction

        function int pending();
            return due_replies.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------------
    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [1:0]             i_func;
    logic [7:0]             i_rx_byte;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [1:0]             o_status;
    logic                   o_send_command;
    logic [COUNT_W-1:0]     o_bytes_stored;

    at_response_receiver_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_send_command (o_send_command),
        .o_bytes_stored (o_bytes_stored)
    );

    t_reply_tracker sb = new();

    int active_items;   // input transfers so far, ignored ones included
    int send_run;       // sender: transfers left in the current gap pattern
    bit send_calm;      // sender: current stretch has no gaps
    int quiet_cycles;   // cycles since the last transfer on either channel

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // wait before the next transfer; runs of gap-free transfers mixed in
    function automatic int draw_wait(inout int run_left, inout bit calm);
        if (run_left == 0) begin
            run_left = $urandom_range(5, 40);
            calm     = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic int capped(int v, int lim);
        return (v < lim) ? v : lim;
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // valid stays up between back-to-back transfers, dropped only for a gap
    task automatic send_item(logic [1:0] func, logic [7:0] data);
        int gap;
        gap = draw_wait(send_run, send_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_rx_byte  <= data;
        do @(posedge i_clk); while (o_in_stall);
        void'(sb.note_input(func, data));
        active_items++;
    endtask

    task automatic tick();
        send_item(FN_TICK, 8'($urandom));
    endtask

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold the sender until every owed result is back and the pipe is empty
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register setting for one phase: extremes first, then random ones
    task automatic set_phase(int p);
        logic [CFG_DATA_W-1:0] pat;
        int                    i;
        case (p)
            0: begin
                cfg_write(CFG_FIRST_TO, '0);
                cfg_write(CFG_IDLE_TO, '0);
                cfg_write(CFG_ATTEMPTS, 64'd255);
                cfg_write(CFG_PATTERN, '1);
                cfg_write(CFG_PAT_LEN, 64'd15);
            end
            1: begin
                cfg_write(CFG_FIRST_TO, 64'hFFFF);
                cfg_write(CFG_IDLE_TO, 64'hFFFF);
                cfg_write(CFG_ATTEMPTS, 64'd1);
                cfg_write(CFG_PATTERN, '0);
                cfg_write(CFG_PAT_LEN, '0);
            end
            default: begin
                for (i = 0; i < PAT_BYTES; i++) begin
                    pat[8*i +: 8] = ($urandom_range(0, 9) == 0) ? 8'h00
                                                               : 8'($urandom_range(1, 255));
                end
                cfg_write(CFG_FIRST_TO, 64'($urandom_range(0, 12)));
                cfg_write(CFG_IDLE_TO, 64'($urandom_range(0, 6)));
                cfg_write(CFG_ATTEMPTS, 64'($urandom_range(1, 4)));
                cfg_write(CFG_PATTERN, pat);
                cfg_write(CFG_PAT_LEN, 64'($urandom_range(0, 15)));
            end
        endcase
    endtask

    // reply bytes lean on the pattern so that matches actually happen
    function automatic logic [7:0] reply_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 8'h00;
        if (r < 60) return sb.pattern[8*$urandom_range(0, PAT_BYTES-1) +: 8];
        return 8'($urandom);
    endfunction

    // one start request and a few attempts: timeouts, replies, some noise
    task automatic run_exchange();
        int tries;
        int n;
        int k;
        int i;
        int plen;
        bit long_reply;
        send_item(FN_START, 8'($urandom));
        tries = $urandom_range(1, 3);
        repeat (tries) begin
            if ($urandom_range(0, 4) == 0) begin
                // no reply at all: run the first-character timer out
                repeat (capped(sb.first_to, 40) + $urandom_range(0, 1)) tick();
            end else begin
                long_reply = ($urandom_range(0, 9) == 0);
                n = long_reply ? BUF_DEPTH_DEF + $urandom_range(1, 4) : $urandom_range(1, 10);
                for (k = 0; k < n; k++) begin
                    if (!long_reply && $urandom_range(0, 3) == 0) begin
                        plen = capped(sb.pat_len, PATTERN_MAX_DEF);
                        for (i = 0; i < plen; i++) send_item(FN_BYTE, sb.pattern[8*i +: 8]);
                    end else begin
                        send_item(FN_BYTE, reply_byte());
                    end
                    // gaps between bytes, now and then long enough to end the reply
                    if (!long_reply && sb.idle_to > 1 && $urandom_range(0, 2) != 0) begin
                        repeat ($urandom_range(0, capped(sb.idle_to - 1, 4))) tick();
                    end else if (!long_reply && $urandom_range(0, 9) == 0) begin
                        repeat (capped(sb.idle_to, 40)) tick();
                    end
                    if ($urandom_range(0, 11) == 0) send_item(2'($urandom), 8'($urandom));
                end
                // silence that closes the reply
                repeat (capped(sb.idle_to, 40) + $urandom_range(0, 1)) tick();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int phase_no;
        int phase_start;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_func      = '0;
        i_rx_byte   = '0;
        send_run    = 0;
        send_calm   = 1'b0;
        active_items = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle receiver ignores ticks, bytes and the unused selector
        tick();
        send_item(FN_BYTE, 8'hA5);
        send_item(2'd3, 8'hFF);
        // start with reset registers, then a zero byte as the first reply byte
        send_item(FN_START, 8'h00);
        send_item(FN_BYTE, 8'h00);
        drain();

        // short timeouts, two sends, pattern "OK"
        cfg_write(CFG_FIRST_TO, 64'd3);
        cfg_write(CFG_IDLE_TO, 64'd2);
        cfg_write(CFG_ATTEMPTS, 64'd2);
        cfg_write(CFG_PATTERN, 64'h4B4F);
        cfg_write(CFG_PAT_LEN, 64'd2);
        // pending reply closes without the pattern and no sends left: fail
        tick();
        tick();
        // no first byte: resend, then the matching reply
        send_item(FN_START, 8'h00);
        repeat (3) tick();
        send_item(FN_BYTE, 8'h4F);
        send_item(2'd3, 8'h00);
        send_item(FN_BYTE, 8'h4B);
        tick();
        tick();
        // pattern reversed, then a restart while waiting, then timeouts to fail
        send_item(FN_START, 8'hFF);
        send_item(FN_BYTE, 8'h4B);
        send_item(FN_BYTE, 8'h4F);
        send_item(FN_START, 8'h55);
        repeat (6) tick();
        drain();

        // no sends allowed: start fails at once, then the byte is ignored
        cfg_write(CFG_ATTEMPTS, '0);
        send_item(FN_START, 8'h00);
        send_item(FN_BYTE, 8'h4F);
        drain();

        // random part, one register setting per phase
        active_items = 0;
        phase_no = 0;
        while (active_items < ITEM_GOAL) begin
            set_phase(phase_no);
            phase_start = active_items;
            while (active_items - phase_start < PHASE_ITEMS && active_items < ITEM_GOAL) begin
                run_exchange();
                if ($urandom_range(0, 5) == 0) drain();
            end
            drain();
            phase_no++;
        end

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side: random stall before each result transfer
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int run_left;
        bit calm;
        int hold;
        run_left    = 0;
        calm        = 1'b0;
        i_out_stall = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = draw_wait(run_left, calm);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // check every result transfer against the oldest owed result
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_status, o_send_command, o_bytes_stored);
        end
    end

    // watchdog: too long without any transfer means the block hung
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial quiet_cycles = 0;

endmodule
